@@ src/lgps_pkg.sv @@
// ----------------------------------------------------------------------------
// Lookahead goal search package
// Shared types and constants for the goal point search block.
// ----------------------------------------------------------------------------
package lgps_pkg;

  localparam int DefMaxSegments = 1024;
  localparam int DefCoordBits   = 24;
  localparam int RadiusBits     = 23;
  localparam int IndexBits      = 10;
  localparam int FoundBits      = 11;
  localparam int CoordW         = 24;
  // internal working widths
  localparam int RelW  = 26;   // relative coordinate
  localparam int DrW   = 54;   // dr squared
  localparam int DdW   = 53;   // cross product magnitude
  localparam int WideW = 128;  // discriminant and numerators
  localparam int SqW   = 64;   // square root
  localparam int QW    = 64;   // quotient
  localparam int PosW  = 44;   // root coordinate range after clamp

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_DR2,
    ST_DD,
    ST_DISC,
    ST_SQRT,
    ST_NUM,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DIV_STORE,
    ST_CHECK,
    ST_DIST,
    ST_DECIDE,
    ST_OUT
  } lgps_state_t;

  // multiply unit request
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } lgps_mul_req_t;

endpackage

@@ src/lgps_mul.sv @@
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 64x64 product built from four registered 32x32 partial products,
// summed into a registered result.
// ----------------------------------------------------------------------------
module lgps_mul
  import lgps_pkg::*;
(
  input  logic          clk,
  input  lgps_mul_req_t req,
  output logic [127:0]  prod
);

  logic [63:0] p00, p01, p10, p11;

  always_ff @(posedge clk) begin
    p00 <= 64'(req.a[31:0])  * 64'(req.b[31:0]);
    p01 <= 64'(req.a[31:0])  * 64'(req.b[63:32]);
    p10 <= 64'(req.a[63:32]) * 64'(req.b[31:0]);
    p11 <= 64'(req.a[63:32]) * 64'(req.b[63:32]);
    prod <= {p11, 64'd0} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {64'd0, p00};
  end

endmodule

@@ src/lgps_div.sv @@
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle over a 128-bit dividend. Saturates the
// quotient at 2^40, as the goal range needs no more.
// ----------------------------------------------------------------------------
module lgps_div
  import lgps_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [127:0]     dividend,
  input  logic [DrW-1:0]   divisor,
  output logic             done,
  output logic [QW-1:0]    quot
);

  logic [127:0]  num;
  logic [DrW:0]  rem;
  logic [QW-1:0] q;
  logic          big;
  logic [7:0]    cnt;
  logic          busy;
  logic [DrW:0]  trial;

  assign trial = {rem[DrW-1:0], num[127]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 8'd0;
      end else if (busy) begin
        cnt <= cnt + 8'd1;
        if (cnt == 8'd127) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      rem <= '0;
      q   <= '0;
      big <= 1'b0;
    end else if (busy) begin
      num <= {num[126:0], 1'b0};
      if (q[QW-1]) big <= 1'b1;
      if (trial >= {1'b0, divisor}) begin
        rem <= trial - {1'b0, divisor};
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (big || q > (64'd1 << 40)) quot = 64'd1 << 40;
    else quot = q;
  end

endmodule

@@ src/lookahead_goal_point_search_unit.sv @@
// ----------------------------------------------------------------------------
// Lookahead goal point search unit
// Intersects the lookahead circle with one path segment per transfer.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (valid/ready) carries one segment with the robot position.
//    first_segment restarts the search at that segment.
//  - Config channel writes lookahead_radius; write it only while idle.
//  - Output channel returns one result per input transfer, held in an output
//    register until taken; a stalled receiver holds the whole block.
//  - The full path is set by the serial units: a 64-step square root and four
//    divisions on one divider, with every product on a single shared
//    multiplier. A missed circle or a degenerate segment skips the root and
//    division steps after the discriminant, and once the search has stopped
//    the result is set in the prep state with no arithmetic.
//  - One segment at a time: ready is low from acceptance until the result
//    transfer completes, so a new segment is taken only after the last result.
//  - Reset clears the last-found state and stop flag and loads radius 3072.
// ----------------------------------------------------------------------------
module lookahead_goal_point_search_unit
  import lgps_pkg::*;
#(
  parameter int MAX_SEGMENTS = DefMaxSegments,
  parameter int COORD_BITS   = DefCoordBits
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [RadiusBits-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     first_segment,
  input  logic [IndexBits-1:0]     segment_index,
  input  logic signed [CoordW-1:0] start_x,
  input  logic signed [CoordW-1:0] start_y,
  input  logic signed [CoordW-1:0] end_x,
  input  logic signed [CoordW-1:0] end_y,
  input  logic signed [CoordW-1:0] robot_x,
  input  logic signed [CoordW-1:0] robot_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     intersect_found,
  output logic                     goal_valid,
  output logic signed [CoordW-1:0] goal_x,
  output logic signed [CoordW-1:0] goal_y,
  output logic                     stop_search,
  output logic [FoundBits-1:0]     last_found_index
);

  localparam int CB = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
  localparam logic signed [PosW-1:0] CMax = PosW'((64'sd1 <<< (CB - 1)) - 1);
  localparam logic signed [PosW-1:0] CMin = -CMax - PosW'(1);
  localparam logic [16:0] MaxSeg = 17'(MAX_SEGMENTS);

  lgps_state_t state, state_next;

  logic [RadiusBits-1:0] radius;
  logic [16:0]           found_index;
  logic signed [CoordW-1:0] found_px, found_py;
  logic                  stopped;

  // latched item
  logic [IndexBits-1:0]  seg;
  logic signed [PosW-1:0] sx, sy, ex, ey, rx, ry;
  logic signed [RelW-1:0] x1, y1, x2, y2, dx, dy;
  logic [DrW-1:0]        dr2;
  logic signed [DdW:0]   dd;
  logic [127:0]          lhs, dsq, disc;
  logic [SqW-1:0]        s;
  logic [127:0]          nax, nbx, nay, nby;
  logic signed [PosW-1:0] p1x, p2x, p1y, p2y;
  logic                  in1, in2;
  logic [127:0]          d1, d2, drb;
  logic [3:0]            step;
  logic [6:0]            bitn;
  logic [1:0]            divsel;

  // shared multiplier
  lgps_mul_req_t mreq;
  logic [127:0]  mprod;
  lgps_mul u_mul (.clk(clk), .req(mreq), .prod(mprod));

  // shared divider
  logic          dstart, ddone;
  logic [127:0]  ddiv;
  logic [QW-1:0] dquot;
  logic          dneg;
  lgps_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(ddiv), .divisor(dr2),
    .done(ddone), .quot(dquot)
  );

  function automatic logic signed [PosW-1:0] sat_in(input logic signed [CoordW-1:0] v);
    logic signed [PosW-1:0] w;
    w = PosW'(v);
    if (w > CMax) return CMax;
    if (w < CMin) return CMin;
    return w;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [PosW+8:0] v);
    logic signed [PosW+8:0] a;
    a = v[PosW+8] ? -v : v;
    return 64'(a);
  endfunction

  function automatic logic [16:0] clamp_idx(input logic [16:0] v);
    return (v > MaxSeg) ? MaxSeg : v;
  endfunction

  function automatic logic [127:0] neg128(input logic [127:0] v);
    return ~v + 128'd1;
  endfunction

  // signed dividend of the root being divided
  logic [127:0] num_sel;
  always_comb begin
    unique case (divsel)
      2'd0:    num_sel = nax + nbx;
      2'd1:    num_sel = nax - nbx;
      2'd2:    num_sel = nay + nby;
      default: num_sel = nay - nby;
    endcase
  end

  logic signed [PosW-1:0] qsigned;
  assign qsigned = dneg ? -PosW'(dquot) : PosW'(dquot);

  // multiplier operand select per state/step
  logic [SqW-1:0] sqc;
  assign sqc = s | (SqW'(1) << bitn[5:0]);

  always_comb begin
    mreq = '0;
    unique case (state)
      ST_DR2: begin
        if (step[0]) mreq = '{mag64(53'(dy)), mag64(53'(dy))};
        else mreq = '{mag64(53'(dx)), mag64(53'(dx))};
      end
      ST_DD: begin
        if (step[0]) mreq = '{mag64(53'(x2)), mag64(53'(y1))};
        else mreq = '{mag64(53'(x1)), mag64(53'(y2))};
      end
      ST_DISC: begin
        if (step[1:0] == 2'd0) mreq = '{64'(radius), 64'(radius)};
        else if (step[1:0] == 2'd1) mreq = '{mag64(53'(dd)), mag64(53'(dd))};
        else mreq = '{lhs[63:0], 64'(dr2)};
      end
      ST_SQRT: mreq = '{sqc, sqc};
      ST_NUM: begin
        unique case (step[1:0])
          2'd0: mreq = '{mag64(53'(dd)), mag64(53'(dy))};
          2'd1: mreq = '{mag64(53'(dx)), s};
          2'd2: mreq = '{mag64(53'(dd)), mag64(53'(dx))};
          default: mreq = '{mag64(53'(dy)), s};
        endcase
      end
      ST_DIST: begin
        unique case (step[2:0])
          3'd0: mreq = '{mag64(53'(p1x - ex)), mag64(53'(p1x - ex))};
          3'd1: mreq = '{mag64(53'(p1y - ey)), mag64(53'(p1y - ey))};
          3'd2: mreq = '{mag64(53'(p2x - ex)), mag64(53'(p2x - ex))};
          3'd3: mreq = '{mag64(53'(p2y - ey)), mag64(53'(p2y - ey))};
          3'd4: mreq = '{mag64(53'(rx - ex)), mag64(53'(rx - ex))};
          default: mreq = '{mag64(53'(ry - ey)), mag64(53'(ry - ey))};
        endcase
      end
      default: mreq = '0;
    endcase
  end

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    dstart = 1'b0;
    ddiv   = num_sel[127] ? neg128(num_sel) + 128'(dr2 >> 1) : num_sel + 128'(dr2 >> 1);
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_PREP;
      ST_PREP:   state_next = stopped ? ST_OUT : ST_DR2;
      ST_DR2:    if (step == 4'd3) state_next = ST_DD;
      ST_DD:     if (step == 4'd3) state_next = ST_DISC;
      ST_DISC:   if (step == 4'd6) begin
        state_next = (dr2 != '0 && dsq <= lhs) ? ST_SQRT : ST_OUT;
      end
      ST_SQRT:   if (step == 4'd2 && bitn == 7'd0) state_next = ST_NUM;
      ST_NUM:    if (step == 4'd5) state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: begin
        dstart = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV:    if (ddone) state_next = ST_DIV_STORE;
      ST_DIV_STORE: state_next = (divsel == 2'd3) ? ST_CHECK : ST_DIV_LOAD;
      ST_CHECK:  state_next = ST_DIST;
      ST_DIST:   if (step == 4'd7) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_OUT;
      ST_OUT:    if (out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // step counter restarts on every state change and after each root bit
  always_ff @(posedge clk) begin
    if (rst || state != state_next || (state == ST_SQRT && step == 4'd2)) step <= '0;
    else step <= step + 4'd1;
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= RadiusBits'(3072);
      found_index <= '0;
      found_px    <= '0;
      found_py    <= '0;
      stopped     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) radius <= cfg_data;
      if (state == ST_OUT && out_ready) out_valid <= 1'b0;
      if (state == ST_IDLE && in_valid) begin
        if (first_segment) begin
          found_index <= clamp_idx(17'(segment_index));
          found_px    <= CoordW'(sat_in(start_x));
          found_py    <= CoordW'(sat_in(start_y));
          stopped     <= 1'b0;
        end
      end
      if (state == ST_PREP && stopped) begin
        intersect_found <= 1'b0;
        goal_valid      <= 1'b0;
        goal_x          <= '0;
        goal_y          <= '0;
        stop_search     <= 1'b1;
        out_valid       <= 1'b1;
      end
      if (state == ST_DISC && step == 4'd6 && !(dr2 != '0 && dsq <= lhs)) begin
        intersect_found <= 1'b0;
        goal_valid      <= 1'b0;
        goal_x          <= '0;
        goal_y          <= '0;
        stop_search     <= 1'b0;
        out_valid       <= 1'b1;
      end
      if (state == ST_DECIDE) begin
        out_valid   <= 1'b1;
        goal_valid  <= 1'b1;
        if (in1 || in2) begin
          intersect_found <= 1'b1;
          // choose root nearer the end
          if (in1 && (!in2 || d1 < d2)) begin
            goal_x <= CoordW'((p1x > CMax) ? CMax : (p1x < CMin) ? CMin : p1x);
            goal_y <= CoordW'((p1y > CMax) ? CMax : (p1y < CMin) ? CMin : p1y);
            if (d1 < drb) begin
              found_index <= clamp_idx(17'(seg));
              found_px <= CoordW'(sx);
              found_py <= CoordW'(sy);
              stopped  <= 1'b1;
              stop_search <= 1'b1;
            end else begin
              found_index <= clamp_idx(17'(seg) + 17'd1);
              found_px <= CoordW'(ex);
              found_py <= CoordW'(ey);
              stop_search <= 1'b0;
            end
          end else begin
            goal_x <= CoordW'((p2x > CMax) ? CMax : (p2x < CMin) ? CMin : p2x);
            goal_y <= CoordW'((p2y > CMax) ? CMax : (p2y < CMin) ? CMin : p2y);
            if (d2 < drb) begin
              found_index <= clamp_idx(17'(seg));
              found_px <= CoordW'(sx);
              found_py <= CoordW'(sy);
              stopped  <= 1'b1;
              stop_search <= 1'b1;
            end else begin
              found_index <= clamp_idx(17'(seg) + 17'd1);
              found_px <= CoordW'(ex);
              found_py <= CoordW'(ey);
              stop_search <= 1'b0;
            end
          end
        end else begin
          // fall back to the stored last-found point
          intersect_found <= 1'b0;
          stop_search     <= 1'b0;
          goal_x <= found_px;
          goal_y <= found_py;
        end
      end
    end
  end

  assign last_found_index = found_index[FoundBits-1:0];

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        seg <= segment_index;
        sx <= sat_in(start_x);
        sy <= sat_in(start_y);
        ex <= sat_in(end_x);
        ey <= sat_in(end_y);
        rx <= sat_in(robot_x);
        ry <= sat_in(robot_y);
      end
      ST_PREP: begin
        x1 <= RelW'(sx - rx);
        y1 <= RelW'(sy - ry);
        x2 <= RelW'(ex - rx);
        y2 <= RelW'(ey - ry);
        dx <= RelW'(ex - sx);
        dy <= RelW'(ey - sy);
      end
      ST_DR2: begin
        if (step == 4'd2) dr2 <= DrW'(mprod);
        if (step == 4'd3) dr2 <= dr2 + DrW'(mprod);
      end
      ST_DD: begin
        // apply the operand signs to each magnitude product
        if (step == 4'd2)
          dd <= ((x1 < 0) != (y2 < 0)) ? -(DdW+1)'(mprod) : (DdW+1)'(mprod);
        if (step == 4'd3)
          dd <= ((x2 < 0) != (y1 < 0)) ? dd + (DdW+1)'(mprod) : dd - (DdW+1)'(mprod);
      end
      ST_DISC: begin
        // step2: rr, step3: dd^2, step5: rr*dr2 issued at step3
        if (step == 4'd2) lhs <= mprod;
        if (step == 4'd3) dsq <= mprod;
        if (step == 4'd5) lhs <= mprod;
        if (step == 4'd6) begin
          disc <= lhs - dsq;
          s    <= '0;
          bitn <= 7'd63;
        end
      end
      ST_SQRT: begin
        if (step == 4'd2) begin
          if (mprod <= disc) s <= sqc;
          bitn <= bitn - 7'd1;
        end
      end
      ST_NUM: begin
        if (step == 4'd2) nax <= ((dd < 0) != (dy < 0)) ? neg128(mprod) : mprod;
        if (step == 4'd3) nbx <= ((dx < 0) != (dy < 0)) ? neg128(mprod) : mprod;
        if (step == 4'd4)
          nay <= ((dd < 0) == (dx < 0) && dd != 0 && dx != 0) ? neg128(mprod) : mprod;
        if (step == 4'd5) begin
          nby    <= mprod;
          divsel <= 2'd0;
        end
      end
      ST_DIV_LOAD: dneg <= num_sel[127];
      ST_DIV_STORE: begin
        unique case (divsel)
          2'd0:    p1x <= qsigned + rx;
          2'd1:    p2x <= qsigned + rx;
          2'd2:    p1y <= qsigned + ry;
          default: p2y <= qsigned + ry;
        endcase
        divsel <= divsel + 2'd1;
      end
      ST_CHECK: begin
        in1 <= ((sx < ex ? sx : ex) <= p1x) && (p1x <= (sx < ex ? ex : sx)) &&
               ((sy < ey ? sy : ey) <= p1y) && (p1y <= (sy < ey ? ey : sy));
        in2 <= ((sx < ex ? sx : ex) <= p2x) && (p2x <= (sx < ex ? ex : sx)) &&
               ((sy < ey ? sy : ey) <= p2y) && (p2y <= (sy < ey ? ey : sy));
      end
      ST_DIST: begin
        unique case (step)
          4'd2: d1  <= mprod;
          4'd3: d1  <= d1 + mprod;
          4'd4: d2  <= mprod;
          4'd5: d2  <= d2 + mprod;
          4'd6: drb <= mprod;
          4'd7: drb <= drb + mprod;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule
